/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files of the press-count code lock.
// Each macro checks on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds
`define AST_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/pcl_pkg.sv */
// Package for the press-count code lock: constants, types and helpers.
// Used by pcl_cfg_regs, pcl_core and press_count_code_lock_top.
package pcl_pkg;

    localparam int unsigned CountW   = 4;
    localparam int unsigned TimeoutW = 16;
    localparam int unsigned ApbAddrW = 4;
    localparam int unsigned ApbDataW = 32;
    localparam int unsigned InDataW  = 8;
    localparam int unsigned OutDataW = 24;

    localparam logic [CountW-1:0]   DIGIT_FULL    = 4'd10;
    localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 16'd2000;
    localparam logic [CountW-1:0]   CODE1_RESET   = 4'd1;
    localparam logic [CountW-1:0]   CODE2_RESET   = 4'd2;
    localparam logic [CountW-1:0]   CODE3_RESET   = 4'd3;

    // Register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_TIMEOUT = 2'd0,
        REG_CODE1   = 2'd1,
        REG_CODE2   = 2'd2,
        REG_CODE3   = 2'd3
    } reg_idx_t;

    // Entry phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DIG1 = 2'd1,
        PH_DIG2 = 2'd2,
        PH_DIG3 = 2'd3
    } phase_t;

    // Configuration handed from the register file to the core
    typedef struct packed {
        logic [TimeoutW-1:0] timeout_ticks;
        logic [CountW-1:0]   code_first;
        logic [CountW-1:0]   code_second;
        logic [CountW-1:0]   code_third;
    } cfg_t;

    // One result item, last field in the lowest bits
    typedef struct packed {
        logic              code_matched;
        logic              code_checked;
        logic [CountW-1:0] count_third;
        logic [CountW-1:0] count_second;
        logic [CountW-1:0] count_first;
        phase_t            phase;
        logic              alarm_on;
    } result_t;

    // Press count increment, saturating at ten
    function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] c);
        return (c < DIGIT_FULL) ? c + 4'd1 : DIGIT_FULL;
    endfunction

endpackage

/* hw/rtl/pcl_cfg_regs.sv */
// APB configuration registers of the press-count code lock.
// Depends on pcl_pkg for the register indexes and the cfg_t struct.
module pcl_cfg_regs
    import pcl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0] prdata,
    output logic                pready,
    output cfg_t                cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
            cfg_reg.code_first    <= CODE1_RESET;
            cfg_reg.code_second   <= CODE2_RESET;
            cfg_reg.code_third    <= CODE3_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_TIMEOUT: cfg_reg.timeout_ticks <= pwdata[TimeoutW-1:0];
                REG_CODE1:   cfg_reg.code_first    <= pwdata[CountW-1:0];
                REG_CODE2:   cfg_reg.code_second   <= pwdata[CountW-1:0];
                REG_CODE3:   cfg_reg.code_third    <= pwdata[CountW-1:0];
                default:     ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            REG_TIMEOUT: prdata = {{(ApbDataW-TimeoutW){1'b0}}, cfg_reg.timeout_ticks};
            REG_CODE1:   prdata = {{(ApbDataW-CountW){1'b0}}, cfg_reg.code_first};
            REG_CODE2:   prdata = {{(ApbDataW-CountW){1'b0}}, cfg_reg.code_second};
            REG_CODE3:   prdata = {{(ApbDataW-CountW){1'b0}}, cfg_reg.code_third};
            default:     prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/pcl_core.sv */
// Lock state and per-tick update of the press-count code lock.
// Depends on pcl_pkg; the result of a step is combinational, state updates on step.
module pcl_core
    import pcl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  logic    button,
    input  cfg_t    cfg,
    output result_t res
);

    phase_t              phase_reg,   phase_next;
    logic [CountW-1:0]   cnt_reg  [3];
    logic [CountW-1:0]   cnt_next [3];
    logic [TimeoutW-1:0] ticks_reg,   ticks_next;
    logic                alarm_reg,   alarm_next;
    logic [1:0]          dsel;
    logic [CountW-1:0]   cur;
    logic [TimeoutW-1:0] rem;
    logic                close;
    logic                checked;
    logic                matched;

    // Digit being entered
    always_comb
    begin
        case (phase_reg)
            PH_DIG1: dsel = 2'd0;
            PH_DIG2: dsel = 2'd1;
            default: dsel = 2'd2;
        endcase
    end

    assign cur   = cnt_reg[dsel];
    assign rem   = (ticks_reg != '0) ? ticks_reg - 16'd1 : '0;
    assign close = (rem == '0) || (cur == DIGIT_FULL);

    // Next state for one tick
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        ticks_next = ticks_reg;
        alarm_next = alarm_reg;
        checked    = 1'b0;
        matched    = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            if (button)
            begin
                cnt_next[0] = sat_inc(cnt_reg[0]);
                ticks_next  = cfg.timeout_ticks;
                phase_next  = PH_DIG1;
            end
        end
        else if (button)
        begin
            cnt_next[dsel] = sat_inc(cur);
            ticks_next     = cfg.timeout_ticks;
        end
        else if (close)
        begin
            if (phase_reg != PH_DIG3)
            begin
                phase_next = phase_t'(phase_reg + 2'd1);
                ticks_next = cfg.timeout_ticks;
            end
            else
            begin
                checked = 1'b1;
                matched = (cnt_reg[0] == cfg.code_first)
                       && (cnt_reg[1] == cfg.code_second)
                       && (cnt_reg[2] == cfg.code_third);
                if (matched)
                begin
                    alarm_next = ~alarm_reg;
                end
                cnt_next[0] = '0;
                cnt_next[1] = '0;
                cnt_next[2] = '0;
                ticks_next  = rem;
                phase_next  = PH_IDLE;
            end
        end
        else
        begin
            ticks_next = rem;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
            cnt_reg[2] <= '0;
            ticks_reg  <= '0;
            alarm_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            ticks_reg <= ticks_next;
            alarm_reg <= alarm_next;
        end
    end

    // Result of this tick
    assign res.alarm_on     = alarm_next;
    assign res.phase        = phase_next;
    assign res.count_first  = cnt_next[0];
    assign res.count_second = cnt_next[1];
    assign res.count_third  = cnt_next[2];
    assign res.code_checked = checked;
    assign res.code_matched = matched;

endmodule

/* hw/rtl/press_count_code_lock_top.sv */
// Press-count code lock: items pass the input register, pcl_core and the output register.
// Throughput is one item per cycle while m_tready is high; pcl_core updates on each step.
// Input and output registers hold up to two items; s_tready drops only while both are full
// and m_tready is low. rst_n (asynchronous, active low) clears the lock state to idle,
// alarm off, and loads the registers with timeout 2000 and code 1, 2, 3.
// Depends on pcl_pkg, pcl_cfg_regs, pcl_core and assert_macros.svh.
`include "assert_macros.svh"

module press_count_code_lock_top
    import pcl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // slave side; tdata: [0] button, rest zero
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,
    // master side; tdata: [0] alarm_on, [2:1] phase, [6:3] count_first,
    // [10:7] count_second, [14:11] count_third, [15] code_checked,
    // [16] code_matched, rest zero
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0] prdata,
    output logic                pready
);

    localparam int unsigned ResW = $bits(result_t);

    cfg_t    cfg;
    result_t res;
    result_t out_data_reg;
    logic    out_vld_reg;
    logic    in_vld_reg;
    logic    in_btn_reg;
    logic    advance;
    logic    step;

    pcl_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pcl_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .button (in_btn_reg),
        .cfg    (cfg),
        .res    (res)
    );

    // Handshake: output slot free or draining this cycle
    assign advance  = !out_vld_reg || m_tready;
    assign step     = in_vld_reg && advance;
    assign s_tready = !in_vld_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_btn_reg <= s_tdata[0];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(OutDataW-ResW){1'b0}}, out_data_reg};

    // Checks
    `AST_IMPL(a_match_needs_check, m_tvalid && out_data_reg.code_matched,
              out_data_reg.code_checked)
    `AST_IMPL(a_check_returns_idle, m_tvalid && out_data_reg.code_checked,
              out_data_reg.phase == PH_IDLE)
    `AST_IMPL(a_idle_counts_clear, m_tvalid && out_data_reg.phase == PH_IDLE,
              out_data_reg.count_first == '0 && out_data_reg.count_second == '0
              && out_data_reg.count_third == '0)
    `AST_NEXT(a_step_shows_result, step, m_tvalid)

endmodule
